// ===== hdl/seven_segment_refresh_controller_macros.svh =====
// Assertion macros shared by the refresh controller RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SEVEN_SEGMENT_REFRESH_CONTROLLER_MACROS_SVH
`define SEVEN_SEGMENT_REFRESH_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("refresh controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("refresh controller check failed");

`endif

// ===== hdl/ssrc_pkg.sv =====
// Types, codes and divide-by-constant helpers for the seven-segment refresh controller.
// Depends on nothing; used by ssrc_format and seven_segment_refresh_controller.
`default_nettype none

package ssrc_pkg;

    localparam int DIGITS  = 8;
    localparam int DIGIT_W = $clog2(DIGITS);

    localparam logic [2:0] CMD_SPEED   = 3'd0;
    localparam logic [2:0] CMD_BATTERY = 3'd1;
    localparam logic [2:0] CMD_TEMP    = 3'd2;
    localparam logic [2:0] CMD_UPDATE  = 3'd3;
    localparam logic [2:0] CMD_DONE    = 3'd4;
    localparam logic [2:0] CMD_ERROR   = 3'd5;
    localparam logic [2:0] CMD_TICK    = 3'd6;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_START = 3'd2;
    localparam logic [2:0] ACT_LEVEL = 3'd3;
    localparam logic [2:0] ACT_END   = 3'd4;

    localparam logic [1:0] PH_INIT = 2'd0;
    localparam logic [1:0] PH_OPER = 2'd1;
    localparam logic [1:0] PH_ERR  = 2'd2;

    localparam logic [2:0] STEP_SHDN_OFF  = 3'd0;
    localparam logic [2:0] STEP_INTENSITY = 3'd1;
    localparam logic [2:0] STEP_FEATURE   = 3'd2;
    localparam logic [2:0] STEP_BLANK     = 3'd3;
    localparam logic [2:0] STEP_SCAN      = 3'd4;
    localparam logic [2:0] STEP_DECODE    = 3'd5;
    localparam logic [2:0] STEP_SHDN_ON   = 3'd6;
    localparam logic [2:0] STEP_IDLE      = 3'd7;

    localparam logic [3:0] A_DIGIT0    = 4'd1;
    localparam logic [3:0] A_DECODE    = 4'd9;
    localparam logic [3:0] A_INTENSITY = 4'd10;
    localparam logic [3:0] A_SCAN      = 4'd11;
    localparam logic [3:0] A_SHUTDOWN  = 4'd12;
    localparam logic [3:0] A_FEATURE   = 4'd14;

    localparam logic [1:0] CFG_INTENSITY = 2'd0;
    localparam logic [1:0] CFG_SCAN      = 2'd1;
    localparam logic [1:0] CFG_DECODE    = 2'd2;
    localparam logic [1:0] CFG_RECOVERY  = 2'd3;

    localparam logic [7:0] BLANK       = 8'h0F;
    localparam logic [7:0] DOT         = 8'h80;
    localparam logic [7:0] SHDN_OFF    = 8'h00;
    localparam logic [7:0] SHDN_ON     = 8'h81;
    localparam logic [7:0] FEATURE_VAL = 8'h00;
    localparam logic [7:0] RC_DONE     = 8'hFF;

    localparam logic [15:0] SPEED_MAX   = 16'd9999;
    localparam logic [15:0] BATTERY_MAX = 16'd1000;
    localparam logic [15:0] TEMP_MAX    = 16'd999;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] value;
        logic        bus_busy;
    } in_word_t;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] reg_addr;
        logic [7:0] reg_data;
        logic       clock_level;
        logic [1:0] phase_now;
    } out_word_t;

    typedef struct packed {
        logic [DIGITS-1:0]      wr_en;
        logic [DIGITS-1:0][7:0] code;
    } fmt_t;

    // Reciprocal multiplications, exact for every 14-bit argument.
    function automatic logic [10:0] div10(input logic [13:0] x);
        logic [29:0] p;
        p = 30'(x) * 30'd52429;
        return p[29:19];
    endfunction

    function automatic logic [7:0] div100(input logic [13:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'd5243;
        return p[26:19];
    endfunction

    function automatic logic [4:0] div1000(input logic [13:0] x);
        logic [27:0] p;
        p = 28'(x) * 28'd8389;
        return p[27:23];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ssrc_format.sv =====
// Turns a set-value word into code-B digit codes with saturation and blanking.
// Depends on ssrc_pkg for the command codes, the fmt_t type and the divide helpers.
`default_nettype none

module ssrc_format
    import ssrc_pkg::*;
(
    input  wire logic [2:0]  cmd,
    input  wire logic [15:0] value,
    output fmt_t             fmt
);

    logic [13:0] sat;
    logic [10:0] q10;
    logic [7:0]  q100;
    logic [4:0]  q1000;
    logic [3:0]  units;
    logic [3:0]  tens;
    logic [3:0]  hundreds;
    logic [3:0]  thousands;

    always_comb
    begin
        case (cmd)
            CMD_SPEED:   sat = (value > SPEED_MAX)   ? SPEED_MAX[13:0]   : value[13:0];
            CMD_BATTERY: sat = (value > BATTERY_MAX) ? BATTERY_MAX[13:0] : value[13:0];
            default:     sat = (value > TEMP_MAX)    ? TEMP_MAX[13:0]    : value[13:0];
        endcase
    end

    assign q10       = div10(sat);
    assign q100      = div100(sat);
    assign q1000     = div1000(sat);
    assign units     = 4'(sat - 14'(q10) * 14'd10);
    assign tens      = 4'(q10 - 11'(q100) * 11'd10);
    assign hundreds  = 4'(q100 - 8'(q1000) * 8'd10);
    assign thousands = q1000[3:0];

    always_comb
    begin
        fmt = '0;
        case (cmd)
            CMD_SPEED:
            begin
                fmt.wr_en[2:0] = 3'b111;
                fmt.code[0]    = {4'h0, tens};
                fmt.code[1]    = {4'h0, hundreds};
                fmt.code[2]    = {4'h0, thousands};
                if (thousands == 4'd0)
                begin
                    fmt.code[2] = BLANK;
                    if (hundreds == 4'd0)
                    begin
                        fmt.code[1] = BLANK;
                    end
                end
            end
            CMD_BATTERY:
            begin
                fmt.wr_en[5:3] = 3'b111;
                if (sat == BATTERY_MAX[13:0])
                begin
                    fmt.code[3] = 8'd0;
                    fmt.code[4] = 8'd0;
                    fmt.code[5] = 8'd1;
                end
                else
                begin
                    fmt.code[3] = {4'h0, units};
                    fmt.code[4] = DOT | {4'h0, tens};
                    fmt.code[5] = (hundreds == 4'd0) ? BLANK : {4'h0, hundreds};
                end
            end
            CMD_TEMP:
            begin
                fmt.wr_en[7:6] = 2'b11;
                fmt.code[6]    = {4'h0, tens};
                fmt.code[7]    = (hundreds == 4'd0) ? BLANK : {4'h0, hundreds};
            end
            default:
            begin
                fmt = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/seven_segment_refresh_controller.sv =====
// Top level of the seven-segment display refresh controller.
// Depends on ssrc_pkg, ssrc_format and the shared assertion macros header.
//
// Event words arrive on item/item_valid/item_stall and each one produces exactly
// one result word on result/result_valid/result_stall. A word is taken at a rising
// edge where valid is high and stall is low.
// Every event is handled in a single pass of logic between the state registers
// and the result register, so a result appears in the cycle after its event is
// taken; one new event per cycle can be taken, sustained while no stall is raised.
// The only stall source is the result register: while it holds a word that the
// receiver stalls, item_stall is raised and nothing changes.
// Configuration words use cfg_valid/cfg_ready with cfg_index and cfg_data; the port
// is always ready and should only be written while no event is outstanding.
// Reset clears the digit buffer, the phase (initialising), the step, digit and
// recovery counters and the error flag, and restores the register defaults.
`default_nettype none
`include "seven_segment_refresh_controller_macros.svh"

module seven_segment_refresh_controller
    import ssrc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire in_word_t   item,
    input  wire logic       item_valid,
    output logic            item_stall,
    output out_word_t       result,
    output logic            result_valid,
    input  wire logic       result_stall,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    logic [3:0]               intensity_reg;
    logic [2:0]               scan_limit_reg;
    logic [7:0]               decode_mask_reg;
    logic [7:0]               recovery_limit_reg;

    logic [DIGITS-1:0][7:0]   digit_codes_reg;
    logic [1:0]               phase_reg;
    logic [1:0]               phase_next;
    logic [2:0]               init_step_reg;
    logic [2:0]               init_step_next;
    logic [DIGIT_W-1:0]       digit_pointer_reg;
    logic [DIGIT_W-1:0]       digit_pointer_next;
    logic [7:0]               recovery_count_reg;
    logic [7:0]               recovery_count_next;
    logic                     error_seen_reg;
    logic                     error_seen_next;

    out_word_t                result_reg;
    out_word_t                result_next;
    logic                     result_valid_reg;
    logic                     accept;
    fmt_t                     fmt;
    logic [3:0]               digit_addr;

    ssrc_format u_format
    (
        .cmd   (item.cmd),
        .value (item.value),
        .fmt   (fmt)
    );

    assign item_stall   = result_valid_reg & result_stall;
    assign accept       = item_valid & ~item_stall;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;
    assign cfg_ready    = 1'b1;
    assign digit_addr   = A_DIGIT0 + 4'(digit_pointer_next);

    always_comb
    begin
        phase_next          = phase_reg;
        init_step_next      = init_step_reg;
        digit_pointer_next  = digit_pointer_reg;
        recovery_count_next = recovery_count_reg;
        error_seen_next     = error_seen_reg;
        result_next         = '0;
        case (item.cmd)
            CMD_UPDATE:
            begin
                if (phase_reg == PH_INIT)
                begin
                    if (!error_seen_reg && init_step_reg == STEP_IDLE)
                    begin
                        phase_next         = PH_OPER;
                        init_step_next     = STEP_SHDN_OFF;
                        digit_pointer_next = '0;
                    end
                    else if (error_seen_reg)
                    begin
                        phase_next = PH_ERR;
                    end
                end
                else if (phase_reg == PH_ERR)
                begin
                    if (recovery_count_reg == RC_DONE)
                    begin
                        phase_next = PH_INIT;
                    end
                end
                else if (error_seen_reg)
                begin
                    phase_next = PH_ERR;
                end

                if (phase_next != PH_ERR && item.bus_busy)
                begin
                    result_next.action = ACT_NONE;
                end
                else if (phase_next == PH_INIT)
                begin
                    if (recovery_count_reg == RC_DONE)
                    begin
                        recovery_count_next = 8'd0;
                    end
                    result_next.action = ACT_WRITE;
                    case (init_step_next)
                        STEP_SHDN_OFF:
                        begin
                            result_next.reg_addr = A_SHUTDOWN;
                            result_next.reg_data = SHDN_OFF;
                        end
                        STEP_INTENSITY:
                        begin
                            result_next.reg_addr = A_INTENSITY;
                            result_next.reg_data = {4'h0, intensity_reg};
                        end
                        STEP_FEATURE:
                        begin
                            result_next.reg_addr = A_FEATURE;
                            result_next.reg_data = FEATURE_VAL;
                        end
                        STEP_BLANK:
                        begin
                            result_next.reg_addr = digit_addr;
                            result_next.reg_data = BLANK;
                        end
                        STEP_SCAN:
                        begin
                            result_next.reg_addr = A_SCAN;
                            result_next.reg_data = {5'h00, scan_limit_reg};
                        end
                        STEP_DECODE:
                        begin
                            result_next.reg_addr = A_DECODE;
                            result_next.reg_data = decode_mask_reg;
                        end
                        STEP_SHDN_ON:
                        begin
                            result_next.reg_addr = A_SHUTDOWN;
                            result_next.reg_data = SHDN_ON;
                        end
                        default:
                        begin
                            result_next.action = ACT_NONE;
                        end
                    endcase
                end
                else if (phase_next == PH_ERR)
                begin
                    if (recovery_count_reg == 8'd0)
                    begin
                        result_next.action      = ACT_START;
                        result_next.clock_level = 1'b1;
                        recovery_count_next     = 8'd1;
                        error_seen_next         = 1'b0;
                    end
                end
                else
                begin
                    result_next.action   = ACT_WRITE;
                    result_next.reg_addr = digit_addr;
                    result_next.reg_data = digit_codes_reg[digit_pointer_next];
                end
            end
            CMD_DONE:
            begin
                if (phase_reg == PH_INIT)
                begin
                    if (init_step_reg == STEP_BLANK)
                    begin
                        if (digit_pointer_reg == DIGIT_W'(DIGITS - 1))
                        begin
                            digit_pointer_next = '0;
                            init_step_next     = STEP_SCAN;
                        end
                        else
                        begin
                            digit_pointer_next = digit_pointer_reg + DIGIT_W'(1);
                        end
                    end
                    else if (init_step_reg != STEP_IDLE)
                    begin
                        init_step_next = init_step_reg + 3'd1;
                    end
                end
                else if (phase_reg == PH_OPER)
                begin
                    if (digit_pointer_reg == DIGIT_W'(DIGITS - 1))
                    begin
                        digit_pointer_next = '0;
                    end
                    else
                    begin
                        digit_pointer_next = digit_pointer_reg + DIGIT_W'(1);
                    end
                end
            end
            CMD_ERROR:
            begin
                error_seen_next = 1'b1;
            end
            CMD_TICK:
            begin
                if (phase_reg == PH_ERR)
                begin
                    if (recovery_count_reg < recovery_limit_reg)
                    begin
                        result_next.action      = ACT_LEVEL;
                        result_next.clock_level = recovery_count_reg[0];
                        recovery_count_next     = recovery_count_reg + 8'd1;
                    end
                    else
                    begin
                        result_next.action  = ACT_END;
                        init_step_next      = STEP_SHDN_OFF;
                        digit_pointer_next  = '0;
                        recovery_count_next = RC_DONE;
                    end
                end
            end
            default:
            begin
                result_next.action = ACT_NONE;
            end
        endcase
        result_next.phase_now = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intensity_reg      <= 4'd15;
            scan_limit_reg     <= 3'd7;
            decode_mask_reg    <= 8'd255;
            recovery_limit_reg <= 8'd18;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INTENSITY: intensity_reg      <= cfg_data[3:0];
                CFG_SCAN:      scan_limit_reg     <= cfg_data[2:0];
                CFG_DECODE:    decode_mask_reg    <= cfg_data;
                CFG_RECOVERY:  recovery_limit_reg <= cfg_data;
                default:       intensity_reg      <= intensity_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_codes_reg    <= '0;
            phase_reg          <= PH_INIT;
            init_step_reg      <= STEP_SHDN_OFF;
            digit_pointer_reg  <= '0;
            recovery_count_reg <= 8'd0;
            error_seen_reg     <= 1'b0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int i = 0; i < DIGITS; i++)
                begin
                    if (fmt.wr_en[i])
                    begin
                        digit_codes_reg[i] <= fmt.code[i];
                    end
                end
                phase_reg          <= phase_next;
                init_step_reg      <= init_step_next;
                digit_pointer_reg  <= digit_pointer_next;
                recovery_count_reg <= recovery_count_next;
                error_seen_reg     <= error_seen_next;
                result_valid_reg   <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    // A taken event always leaves a result word behind it.
    `SSRC_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, result_valid)
    // A clean update in the operational phase always refreshes a digit.
    `SSRC_ASSERT_NEXT(a_oper_refresh, clk, rst_n,
        accept && item.cmd == CMD_UPDATE && phase_reg == PH_OPER
            && !error_seen_reg && !item.bus_busy,
        result.action == ACT_WRITE && result.phase_now == PH_OPER)
    // Recovery ticks outside the error phase do nothing.
    `SSRC_ASSERT_NEXT(a_tick_ignored, clk, rst_n,
        accept && item.cmd == CMD_TICK && phase_reg != PH_ERR,
        result.action == ACT_NONE && $stable(recovery_count_reg))

endmodule

`default_nettype wire

// ===== bench/seven_segment_refresh_controller_tb.sv =====
// Self-checking testbench for the seven-segment display refresh controller.
// Depends on ssrc_pkg and the seven_segment_refresh_controller RTL; it reads no files.
// It runs a directed table, then random event words under several idling patterns.
`default_nettype none

module seven_segment_refresh_controller_tb;
    import ssrc_pkg::*;

    localparam logic [2:0] CMD_NOP = 3'd7;
    localparam int ROWS = 25;
    localparam int ITEMS_PER_PHASE = 412;

    localparam out_word_t NONE_INIT = '{ACT_NONE, 4'd0, 8'd0, 1'b0, PH_INIT};
    localparam out_word_t NONE_ERR  = '{ACT_NONE, 4'd0, 8'd0, 1'b0, PH_ERR};
    localparam out_word_t SHDN_WR   = '{ACT_WRITE, A_SHUTDOWN, SHDN_OFF, 1'b0, PH_INIT};
    localparam out_word_t END_REC   = '{ACT_END, 4'd0, 8'd0, 1'b0, PH_ERR};

    typedef struct packed {
        in_word_t  w;
        logic      typed;
        out_word_t want;
    } row_t;

    localparam row_t PLAN [ROWS] = '{
        '{'{CMD_UPDATE,  16'd0,     1'b0}, 1'b1, SHDN_WR},
        '{'{CMD_SPEED,   16'hFFFF,  1'b0}, 1'b1, NONE_INIT},
        '{'{CMD_BATTERY, 16'd1000,  1'b1}, 1'b1, NONE_INIT},
        '{'{CMD_TEMP,    16'hFFFF,  1'b0}, 1'b1, NONE_INIT},
        '{'{CMD_UPDATE,  16'd0,     1'b1}, 1'b1, NONE_INIT},
        '{'{CMD_NOP,     16'hFFFF,  1'b1}, 1'b1, NONE_INIT},
        '{'{CMD_DONE,    16'd0,     1'b0}, 1'b1, NONE_INIT},
        '{'{CMD_UPDATE,  16'd0,     1'b0}, 1'b1,
          '{ACT_WRITE, A_INTENSITY, 8'd15, 1'b0, PH_INIT}},
        '{'{CMD_DONE,    16'd0,     1'b0}, 1'b1, NONE_INIT},
        '{'{CMD_TICK,    16'd0,     1'b0}, 1'b1, NONE_INIT},
        '{'{CMD_ERROR,   16'd0,     1'b0}, 1'b1, NONE_INIT},
        '{'{CMD_UPDATE,  16'd0,     1'b1}, 1'b1, '{ACT_START, 4'd0, 8'd0, 1'b1, PH_ERR}},
        '{'{CMD_DONE,    16'd0,     1'b0}, 1'b1, NONE_ERR},
        '{'{CMD_TICK,    16'd0,     1'b0}, 1'b1, '{ACT_LEVEL, 4'd0, 8'd0, 1'b1, PH_ERR}},
        '{'{CMD_TICK,    16'd0,     1'b0}, 1'b1, END_REC},
        '{'{CMD_TICK,    16'd0,     1'b0}, 1'b1, END_REC},
        '{'{CMD_UPDATE,  16'd0,     1'b1}, 1'b1, NONE_INIT},
        '{'{CMD_UPDATE,  16'd0,     1'b0}, 1'b1, SHDN_WR},
        '{'{CMD_SPEED,   16'd0,     1'b0}, 1'b0, NONE_INIT},
        '{'{CMD_SPEED,   16'd1000,  1'b0}, 1'b0, NONE_INIT},
        '{'{CMD_BATTERY, 16'd0,     1'b0}, 1'b0, NONE_INIT},
        '{'{CMD_BATTERY, 16'd999,   1'b1}, 1'b0, NONE_INIT},
        '{'{CMD_TEMP,    16'd0,     1'b0}, 1'b0, NONE_INIT},
        '{'{CMD_TEMP,    16'd50,    1'b0}, 1'b0, NONE_INIT},
        '{'{CMD_SPEED,   16'd10050, 1'b1}, 1'b0, NONE_INIT}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    in_word_t   item = '0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    out_word_t  result;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_INTENSITY;
    logic [7:0] cfg_data = 8'd0;

    int idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;

    out_word_t pending_results [$];

    logic [7:0] digit_buf [DIGITS];
    logic [1:0] ctl_phase;
    logic [2:0] ctl_step;
    logic [2:0] ctl_digit;
    logic [7:0] rec_count;
    logic       err_flag;
    logic [3:0] reg_intensity;
    logic [2:0] reg_scan;
    logic [7:0] reg_decode;
    logic [7:0] reg_rec_limit;

    seven_segment_refresh_controller uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic out_word_t predict_display(input in_word_t w);
        out_word_t r;
        int v;
        int d0;
        int d1;
        int d2;
        r = '0;
        case (w.cmd)
            CMD_SPEED:
            begin
                v = (w.value > SPEED_MAX) ? int'(SPEED_MAX) : int'(w.value);
                d0 = (v / 10) % 10;
                d1 = (v / 100) % 10;
                d2 = (v / 1000) % 10;
                if (d2 == 0)
                begin
                    d2 = BLANK;
                    if (d1 == 0)
                        d1 = BLANK;
                end
                digit_buf[0] = 8'(d0);
                digit_buf[1] = 8'(d1);
                digit_buf[2] = 8'(d2);
            end
            CMD_BATTERY:
            begin
                v = (w.value > BATTERY_MAX) ? int'(BATTERY_MAX) : int'(w.value);
                if (v == int'(BATTERY_MAX))
                begin
                    digit_buf[3] = 8'd0;
                    digit_buf[4] = 8'd0;
                    digit_buf[5] = 8'd1;
                end
                else
                begin
                    d2 = v / 100;
                    digit_buf[3] = 8'(v % 10);
                    digit_buf[4] = 8'((v / 10) % 10) | DOT;
                    digit_buf[5] = (d2 == 0) ? BLANK : 8'(d2);
                end
            end
            CMD_TEMP:
            begin
                v = (w.value > TEMP_MAX) ? int'(TEMP_MAX) : int'(w.value);
                d1 = (v / 100) % 10;
                digit_buf[6] = 8'((v / 10) % 10);
                digit_buf[7] = (d1 == 0) ? BLANK : 8'(d1);
            end
            CMD_UPDATE:
            begin
                if (ctl_phase == PH_INIT)
                begin
                    if (!err_flag && ctl_step == STEP_IDLE)
                    begin
                        ctl_phase = PH_OPER;
                        ctl_step = STEP_SHDN_OFF;
                        ctl_digit = '0;
                    end
                    else if (err_flag)
                        ctl_phase = PH_ERR;
                end
                else if (ctl_phase == PH_ERR)
                begin
                    if (rec_count == RC_DONE)
                        ctl_phase = PH_INIT;
                end
                else if (err_flag)
                    ctl_phase = PH_ERR;

                if (ctl_phase == PH_ERR)
                begin
                    if (rec_count == 8'd0)
                    begin
                        r.action = ACT_START;
                        r.clock_level = 1'b1;
                        rec_count = 8'd1;
                        err_flag = 1'b0;
                    end
                end
                else if (!w.bus_busy)
                begin
                    r.action = ACT_WRITE;
                    if (ctl_phase == PH_INIT)
                    begin
                        if (rec_count == RC_DONE)
                            rec_count = 8'd0;
                        case (ctl_step)
                            STEP_SHDN_OFF:
                            begin
                                r.reg_addr = A_SHUTDOWN;
                                r.reg_data = SHDN_OFF;
                            end
                            STEP_INTENSITY:
                            begin
                                r.reg_addr = A_INTENSITY;
                                r.reg_data = 8'(reg_intensity);
                            end
                            STEP_FEATURE:
                            begin
                                r.reg_addr = A_FEATURE;
                                r.reg_data = FEATURE_VAL;
                            end
                            STEP_BLANK:
                            begin
                                r.reg_addr = A_DIGIT0 + 4'(ctl_digit);
                                r.reg_data = BLANK;
                            end
                            STEP_SCAN:
                            begin
                                r.reg_addr = A_SCAN;
                                r.reg_data = 8'(reg_scan);
                            end
                            STEP_DECODE:
                            begin
                                r.reg_addr = A_DECODE;
                                r.reg_data = reg_decode;
                            end
                            STEP_SHDN_ON:
                            begin
                                r.reg_addr = A_SHUTDOWN;
                                r.reg_data = SHDN_ON;
                            end
                            default:
                                r.action = ACT_NONE;
                        endcase
                    end
                    else
                    begin
                        r.reg_addr = A_DIGIT0 + 4'(ctl_digit);
                        r.reg_data = digit_buf[ctl_digit];
                    end
                end
            end
            CMD_DONE:
            begin
                if (ctl_phase == PH_INIT)
                begin
                    if (ctl_step == STEP_BLANK)
                    begin
                        if (ctl_digit == 3'(DIGITS - 1))
                        begin
                            ctl_digit = '0;
                            ctl_step = STEP_SCAN;
                        end
                        else
                            ctl_digit = ctl_digit + 3'd1;
                    end
                    else if (ctl_step != STEP_IDLE)
                        ctl_step = ctl_step + 3'd1;
                end
                else if (ctl_phase == PH_OPER)
                    ctl_digit = ctl_digit + 3'd1;
            end
            CMD_ERROR:
                err_flag = 1'b1;
            CMD_TICK:
            begin
                if (ctl_phase == PH_ERR)
                begin
                    if (rec_count < reg_rec_limit)
                    begin
                        r.action = ACT_LEVEL;
                        r.clock_level = rec_count[0];
                        rec_count = rec_count + 8'd1;
                    end
                    else
                    begin
                        r.action = ACT_END;
                        ctl_step = STEP_SHDN_OFF;
                        ctl_digit = '0;
                        rec_count = RC_DONE;
                    end
                end
            end
            default: ;
        endcase
        r.phase_now = ctl_phase;
        return r;
    endfunction

    function automatic logic [15:0] random_value();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(65535));
            1:       return 16'($urandom_range(1200));
            2:       return 16'($urandom_range(9990, 10010));
            default: return 16'($urandom_range(120));
        endcase
    endfunction

    // Mostly well-formed traffic: update and transfer-done pairs walk through the
    // initialisation and the digit refresh, ticks dominate once recovery is running.
    function automatic in_word_t next_event();
        in_word_t w;
        int r;
        w.value = random_value();
        w.bus_busy = 1'($urandom_range(1));
        r = $urandom_range(99);
        if (ctl_phase == PH_ERR)
        begin
            if (r < 80)
                w.cmd = CMD_TICK;
            else if (r < 90)
                w.cmd = CMD_UPDATE;
            else
                w.cmd = 3'($urandom_range(int'(CMD_SPEED), int'(CMD_NOP)));
        end
        else
        begin
            if (r < 30)
            begin
                w.cmd = CMD_UPDATE;
                w.bus_busy = ($urandom_range(9) == 0);
            end
            else if (r < 62)
                w.cmd = CMD_DONE;
            else if (r < 88)
                w.cmd = 3'($urandom_range(int'(CMD_SPEED), int'(CMD_TEMP)));
            else if (r < 89)
                w.cmd = CMD_ERROR;
            else if (r < 93)
                w.cmd = CMD_TICK;
            else if (r < 96)
                w.cmd = CMD_NOP;
            else
                w.cmd = 3'($urandom_range(int'(CMD_SPEED), int'(CMD_NOP)));
        end
        return w;
    endfunction

    task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
        out_word_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predicted = predict_display(w);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_registers(input int inten, input int scan, input int decode,
                                 input int rec_limit);
        for (int idx = int'(CFG_INTENSITY); idx <= int'(CFG_RECOVERY); idx++)
        begin
            cfg_index <= 2'(idx);
            case (2'(idx))
                CFG_INTENSITY: cfg_data <= 8'(inten);
                CFG_SCAN:      cfg_data <= 8'(scan);
                CFG_DECODE:    cfg_data <= 8'(decode);
                default:       cfg_data <= 8'(rec_limit);
            endcase
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        reg_intensity = 4'(inten);
        reg_scan = 3'(scan);
        reg_decode = 8'(decode);
        reg_rec_limit = 8'(rec_limit);
    endtask

    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report("unexpected result word", int'(result), 0);
            else
            begin
                want = pending_results.pop_front();
                if (result.action !== want.action)
                    report("action", int'(result.action), int'(want.action));
                if (result.reg_addr !== want.reg_addr)
                    report("reg_addr", int'(result.reg_addr), int'(want.reg_addr));
                if (result.reg_data !== want.reg_data)
                    report("reg_data", int'(result.reg_data), int'(want.reg_data));
                if (result.clock_level !== want.clock_level)
                    report("clock_level", int'(result.clock_level),
                           int'(want.clock_level));
                if (result.phase_now !== want.phase_now)
                    report("phase_now", int'(result.phase_now), int'(want.phase_now));
            end
        end
    end

    initial
    begin
        #(8 * 300000);
        $display("** seven_segment_refresh_controller: FAILED **");
        $finish;
    end

    initial
    begin
        int send_idle [4] = '{0, 64, 0, 19};
        int recv_stall [4] = '{0, 0, 64, 19};
        for (int i = 0; i < DIGITS; i++)
            digit_buf[i] = 8'd0;
        ctl_phase = PH_INIT;
        ctl_step = STEP_SHDN_OFF;
        ctl_digit = '0;
        rec_count = 8'd0;
        err_flag = 1'b0;
        reg_intensity = 4'd15;
        reg_scan = 3'd7;
        reg_decode = 8'd255;
        reg_rec_limit = 8'd18;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A short recovery bound lets the directed table reach the end of recovery.
        set_registers(15, 7, 255, 2);
        for (int i = 0; i < ROWS; i++)
            send_word(PLAN[i].w, PLAN[i].typed, PLAN[i].want);
        drain_results();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = send_idle[p];
            stall_pct = recv_stall[p];
            case (p)
                0:       set_registers(0, 0, 0, 2);
                1:       set_registers(15, 7, 255, 254);
                default: set_registers($urandom_range(15), $urandom_range(7),
                                       $urandom_range(255), $urandom_range(2, 40));
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_word(next_event(), 1'b0, '0);
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("** seven_segment_refresh_controller: PASSED **");
        else
            $display("** seven_segment_refresh_controller: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
